@@ design/sstf_pkg.sv @@
// Shared types and constants for the shortest-seek-first disk request scheduler.
package sstf_pkg;

  // Fixed field widths of the transfer payloads.
  localparam int CYL_W  = 16;
  localparam int SEEK_W = 22;

  // The running seek total saturates at the largest value the result field holds.
  localparam logic [SEEK_W-1:0] SEEK_LIMIT = {SEEK_W{1'b1}};

  // One request transfer.
  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic [CYL_W-1:0] start_head;
    logic             batch_end;
  } sstf_in_t;

  // One result transfer.
  typedef struct packed {
    logic [CYL_W-1:0]  served_cylinder;
    logic [SEEK_W-1:0] seek_total;
    logic              final_result;
  } sstf_out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } sstf_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // a request transfer is taken this cycle
    logic batch_start;  // the accepted request closes the batch
    logic issue;        // read the next store entry for the nearest search
    logic emit;         // serve the chosen request and load the result register
  } sstf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;    // the read being issued is the last stored entry
    logic step_last;    // the request being served is the last of the batch
    logic out_ready;    // the result register can take a new result
  } sstf_sts_t;

endpackage

@@ design/sstf_ctrl.sv @@
// Controller state machine that sequences loading, nearest search and serving.
module sstf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_batch_end,
  input  sstf_pkg::sstf_sts_t sts,
  output logic                in_stall,
  output sstf_pkg::sstf_cmd_t cmd
);
  import sstf_pkg::*;

  sstf_state_t state_r;
  sstf_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_valid && in_batch_end) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_ready) begin
          state_nxt = sts.step_last ? ST_LOAD : ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Output decode.
  always_comb begin
    in_stall        = 1'b1;
    cmd.accept      = 1'b0;
    cmd.batch_start = 1'b0;
    cmd.issue       = 1'b0;
    cmd.emit        = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_stall        = 1'b0;
        cmd.accept      = in_valid;
        cmd.batch_start = in_valid && in_batch_end;
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd.issue = 1'b0;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_ready;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ design/sstf_dpath.sv @@
// Datapath: request store, served mask, nearest-request search and result register.
module sstf_dpath #(
  parameter int MAX_REQUESTS  = 64,
  parameter int CYLINDER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sstf_pkg::sstf_in_t  in_data,
  input  sstf_pkg::sstf_cmd_t cmd,
  input  logic                out_stall,
  output sstf_pkg::sstf_sts_t sts,
  output logic                out_valid,
  output sstf_pkg::sstf_out_t out_data
);
  import sstf_pkg::*;

  // Cylinders keep at most the bits that the field carries.
  localparam int CW  = (CYLINDER_BITS < CYL_W) ? CYLINDER_BITS : CYL_W;
  localparam int AW  = $clog2(MAX_REQUESTS);
  localparam int NW  = $clog2(MAX_REQUESTS + 1);
  localparam int SW1 = SEEK_W + 1;

  logic [CW-1:0]     mem [MAX_REQUESTS];
  logic [CW-1:0]     rd_data_r;

  logic [NW-1:0]     count_r, count_nxt;
  logic [MAX_REQUESTS-1:0] served_r, served_nxt;
  logic [CW-1:0]     head_r, head_nxt;
  logic [SEEK_W-1:0] seek_r, seek_nxt;
  logic [AW-1:0]     scan_r, scan_nxt;
  logic [AW-1:0]     step_r, step_nxt;
  logic              cmp_vld_r;
  logic [AW-1:0]     cmp_idx_r;
  logic              found_r, found_nxt;
  logic [AW-1:0]     best_idx_r;
  logic [CW-1:0]     best_dist_r;
  logic [CW-1:0]     best_cyl_r;
  logic              out_valid_r, out_valid_nxt;
  sstf_out_t         out_data_r;

  logic              wr_en;
  logic [NW-1:0]     last_idx;
  logic [CW-1:0]     cand_dist;
  logic              take;
  logic [SW1-1:0]    seek_sum;
  logic [SEEK_W-1:0] seek_sat;

  // Store write for each accepted request while there is room.
  assign wr_en = cmd.accept && (count_r < NW'(MAX_REQUESTS));

  // Request store with a registered read port driven by the scan index.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= in_data.cylinder[CW-1:0];
    end
    rd_data_r <= mem[scan_r];
  end

  // Index of the last stored entry and end-of-pass flags.
  assign last_idx       = count_r - 1'b1;
  assign sts.scan_last  = (NW'(scan_r) == last_idx);
  assign sts.step_last  = (NW'(step_r) == last_idx);
  assign sts.out_ready  = !out_valid_r || !out_stall;

  // Distance of the entry just read from the head; strict less keeps the lowest index on ties.
  assign cand_dist = (rd_data_r >= head_r) ? (rd_data_r - head_r) : (head_r - rd_data_r);
  assign take = cmp_vld_r && !served_r[cmp_idx_r] && (!found_r || (cand_dist < best_dist_r));

  // Saturating running seek total.
  assign seek_sum = {1'b0, seek_r} + SW1'(best_dist_r);
  assign seek_sat = (seek_sum > {1'b0, SEEK_LIMIT}) ? SEEK_LIMIT : seek_sum[SEEK_W-1:0];

  // Next values of the control state.
  always_comb begin
    count_nxt     = count_r;
    served_nxt    = served_r;
    head_nxt      = head_r;
    seek_nxt      = seek_r;
    scan_nxt      = scan_r;
    step_nxt      = step_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (wr_en) begin
      count_nxt = count_r + 1'b1;
    end
    if (take) begin
      found_nxt = 1'b1;
    end
    if (cmd.issue && !sts.scan_last) begin
      scan_nxt = scan_r + 1'b1;
    end
    if (cmd.batch_start) begin
      head_nxt   = in_data.start_head[CW-1:0];
      seek_nxt   = '0;
      served_nxt = '0;
      step_nxt   = '0;
      scan_nxt   = '0;
      found_nxt  = 1'b0;
    end
    if (cmd.emit) begin
      head_nxt               = best_cyl_r;
      seek_nxt               = seek_sat;
      served_nxt[best_idx_r] = 1'b1;
      step_nxt               = step_r + 1'b1;
      scan_nxt               = '0;
      found_nxt              = 1'b0;
      out_valid_nxt          = 1'b1;
      if (sts.step_last) begin
        count_nxt = '0;
      end
    end
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      served_r    <= '0;
      head_r      <= '0;
      seek_r      <= '0;
      scan_r      <= '0;
      step_r      <= '0;
      found_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      served_r    <= served_nxt;
      head_r      <= head_nxt;
      seek_r      <= seek_nxt;
      scan_r      <= scan_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
      cmp_vld_r   <= cmd.issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Search pipeline payload and the best candidate so far.
  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_r;
    if (take) begin
      best_idx_r  <= cmp_idx_r;
      best_dist_r <= cand_dist;
      best_cyl_r  <= rd_data_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.served_cylinder <= CYL_W'(best_cyl_r);
      out_data_r.seek_total      <= seek_sat;
      out_data_r.final_result    <= sts.step_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result is only produced when a candidate was found and the register is free.
  a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (found_r && (!out_valid_r || !out_stall)))
    else $error("result emitted without a free register or a candidate");

  // The chosen request has not been served earlier in this batch.
  a_emit_unserved: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !served_r[best_idx_r])
    else $error("request served twice in one batch");

  // Serving the last request empties the store for the next batch.
  a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.step_last) |=> (count_r == '0))
    else $error("store not emptied after the final result");

  // The search never runs on an empty batch.
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue || cmd.emit) |-> (count_r != '0))
    else $error("search started on an empty store");

endmodule

@@ design/sstf_disk_request_scheduler.sv @@
// Top level of the shortest-seek-first disk request scheduler.
// Requests load at one per cycle: each transfer appends its cylinder to a store of
// MAX_REQUESTS entries, and requests beyond that are dropped. The transfer with
// batch_end set also gives the start head and begins scheduling; in_stall stays high
// until the whole batch is served. Serving runs one step per request of the batch:
// each step reads the store once per entry through its single registered read port to
// find the nearest unserved cylinder (lowest load index on ties), then drains the search
// pipeline and loads the result register, which waits while the previous result is
// still stalled. The next batch may load while the final result is still waiting to
// be taken.
module sstf_disk_request_scheduler #(
  parameter int MAX_REQUESTS  = 64,
  parameter int CYLINDER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sstf_pkg::sstf_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sstf_pkg::sstf_out_t out_data
);
  import sstf_pkg::*;

  sstf_cmd_t cmd;
  sstf_sts_t sts;

  // Controller.
  sstf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_batch_end (in_data.batch_end),
    .sts          (sts),
    .in_stall     (in_stall),
    .cmd          (cmd)
  );

  // Datapath.
  sstf_dpath #(
    .MAX_REQUESTS  (MAX_REQUESTS),
    .CYLINDER_BITS (CYLINDER_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
